### design/rrw_pkg.sv
// ----------------------------------------------------------------------------
// rrw_pkg: shared types and constants for the receive reorder window
// Request and result payloads, result and action codes, and the control
// and status groups that pass between the sequencer and the slot store.
// ----------------------------------------------------------------------------
package rrw_pkg;

  // action codes of an input request
  localparam logic ACTION_DATA    = 1'b0;
  localparam logic ACTION_TIMEOUT = 1'b1;

  // result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // offsets at or above this are old packets
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef struct packed {
    logic        action;
    logic [31:0] packet_sequence;
    logic [31:0] payload_descriptor;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] delivered_descriptor;
    logic [31:0] ack_sequence;
    logic        last;
  } res_t;

  // sequencer to slot store
  typedef struct packed {
    logic clr;    // empty the window
    logic wr_en;  // store a descriptor at an offset from the head
    logic pop;    // retire the head slot and advance the head
  } slot_cmd_t;

  // slot store to sequencer
  typedef struct packed {
    logic head_valid;  // slot 0 holds a packet
    logic next_valid;  // slot 1 holds a packet
    logic empty;       // no slot holds a packet
  } slot_stat_t;

endpackage

### design/rrw_stream_if.sv
// ----------------------------------------------------------------------------
// rrw_stream_if: valid/ready channel
// Carries one payload per handshake; payload type is set per instance.
// ----------------------------------------------------------------------------
interface rrw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/receive_reorder_window.sv
// ----------------------------------------------------------------------------
// receive_reorder_window: selective-repeat receiver reorder window
// Buffers packets by sequence offset, delivers contiguous runs in order and
// issues immediate or delayed cumulative acks, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Order: a request is decided in the cycle after acceptance; an ack alone
//   goes from the decide state through the ack state into the output
//   register; each delivered slot passes a read state (head read from the
//   slot memory) and an output state (output load), an ack the ack state.
// Flow: one request at a time; the next one is taken after every delivery,
//   ack and held-run flush of the last, later while the result side stalls.
// Reset: control state, valid bits and counters clear at once; the
//   descriptor memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module receive_reorder_window #(
  parameter int unsigned WINDOW_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rrw_stream_if.sink   req_i,
  rrw_stream_if.source res_o
);

  localparam int unsigned IW = $clog2(WINDOW_SLOTS);
  localparam logic [IW-1:0] IDX_ZERO = IW'(0);
  localparam logic [IW-1:0] IDX_ONE  = IW'(1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DECIDE  = 5'b00010,
    S_RUN_RD  = 5'b00100,
    S_RUN_OUT = 5'b01000,
    S_ACK     = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [31:0]         exp_q, exp_d;
  logic                gap_q, gap_d;
  logic                dap_q, dap_d;
  logic                act_q, act_d;
  logic [31:0]         seq_q, seq_d;
  logic [31:0]         desc_q, desc_d;
  logic                ack_after_q, ack_after_d;
  logic                recalc_q, recalc_d;
  logic                hold_q, hold_d;
  rrw_pkg::res_t       out_q, out_d;
  logic                out_valid_q, out_valid_d;

  rrw_pkg::slot_cmd_t  cmd;
  rrw_pkg::slot_stat_t stat;
  logic [IW-1:0]       wr_off;
  logic [31:0]         rd_data;

  logic [31:0]         diff;
  logic                ahead;
  logic                in_window;
  logic                out_free;

  rrw_slots #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .wr_off_i (wr_off),
    .wr_data_i(desc_q),
    .stat_o   (stat),
    .rd_data_o(rd_data)
  );

  // shared offset unit: packet position relative to the expected number
  assign diff      = seq_q - exp_q;
  assign ahead     = (diff != 32'd0) && (diff < rrw_pkg::HALF_RANGE);
  assign in_window = (diff < 32'(WINDOW_SLOTS));
  assign out_free  = !out_valid_q || res_o.ready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    gap_d       = gap_q;
    dap_d       = dap_q;
    act_d       = act_q;
    seq_d       = seq_q;
    desc_d      = desc_q;
    ack_after_d = ack_after_q;
    recalc_d    = recalc_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    wr_off      = IDX_ZERO;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d   = req_i.payload.action;
          seq_d   = req_i.payload.packet_sequence;
          desc_d  = req_i.payload.payload_descriptor;
          hold_d  = 1'b0;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        // release a held delivery once it is known whether more follows
        hold_d = 1'b0;
        if (hold_q) begin
          out_valid_d = 1'b1;
          out_d.last  = !(((diff == 32'd0) && gap_q) || ahead);
        end
        ack_after_d = 1'b0;
        recalc_d    = 1'b0;
        state_d     = S_IDLE;
        if (act_q == rrw_pkg::ACTION_TIMEOUT) begin
          dap_d = 1'b0;
          if (stat.head_valid) begin
            ack_after_d = 1'b1;
            state_d     = S_RUN_RD;
          end
        end else if (dap_q) begin
          // delayed ack pending: deliver the held run in every case
          dap_d   = 1'b0;
          state_d = S_RUN_RD;
          if (diff == 32'd1) begin
            cmd.wr_en   = 1'b1;
            wr_off      = IDX_ONE;
            ack_after_d = 1'b1;
          end else if (diff == 32'd0) begin
            ack_after_d = 1'b1;
          end
        end else if (diff == 32'd0) begin
          cmd.wr_en = 1'b1;
          wr_off    = IDX_ZERO;
          if (!gap_q) begin
            dap_d = 1'b1;
          end else begin
            ack_after_d = 1'b1;
            recalc_d    = 1'b1;
            state_d     = S_RUN_RD;
          end
        end else if (ahead) begin
          gap_d = 1'b1;
          if (in_window) begin
            cmd.wr_en = 1'b1;
            wr_off    = diff[IW-1:0];
          end
          state_d = S_ACK;
        end
      end

      S_RUN_RD: begin
        state_d = S_RUN_OUT;
      end

      S_RUN_OUT: begin
        if (out_free) begin
          out_d.result_kind          = rrw_pkg::KIND_DELIVER;
          out_d.delivered_descriptor = rd_data;
          out_d.ack_sequence         = exp_q + 32'd1;
          out_d.last                 = 1'b0;
          out_valid_d                = 1'b1;
          exp_d                      = exp_q + 32'd1;
          cmd.pop                    = 1'b1;
          if (stat.next_valid) begin
            state_d = S_RUN_RD;
          end else if (ack_after_q) begin
            state_d = S_ACK;
          end else begin
            // run ends before normal handling: hold until that is decided
            out_valid_d = 1'b0;
            hold_d      = 1'b1;
            state_d     = S_DECIDE;
          end
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_d.result_kind          = rrw_pkg::KIND_ACK;
          out_d.delivered_descriptor = 32'd0;
          out_d.ack_sequence         = exp_q;
          out_d.last                 = 1'b1;
          out_valid_d                = 1'b1;
          if (recalc_q) begin
            gap_d = !stat.empty;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // register write reloads the expectation and empties the window
    if (cfg_we_i) begin
      exp_d   = cfg_wdata_i;
      gap_d   = 1'b0;
      dap_d   = 1'b0;
      cmd     = '0;
      cmd.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      exp_q       <= 32'd0;
      gap_q       <= 1'b0;
      dap_q       <= 1'b0;
      ack_after_q <= 1'b0;
      recalc_q    <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      gap_q       <= gap_d;
      dap_q       <= dap_d;
      ack_after_q <= ack_after_d;
      recalc_q    <= recalc_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    seq_q  <= seq_d;
    desc_q <= desc_d;
    out_q  <= out_d;
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  // a run read always starts from an occupied head slot
  a_run_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN_RD) && !$past(cfg_we_i) |-> stat.head_valid)
    else $error("run started on empty head slot");

  // a pending delayed ack always has the in-order packet buffered
  a_dap_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dap_q |-> stat.head_valid)
    else $error("delayed ack pending without head slot");

  // each delivery advances the expected number by one
  a_delivery_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN_OUT) && out_free && !cfg_we_i |=>
      exp_q == $past(exp_q) + 32'd1)
    else $error("delivery did not advance expected sequence");

  // a held delivery is only resolved in the decide step, never shown early
  a_hold_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (state_q == S_DECIDE) && !out_valid_q)
    else $error("held delivery outside decide step");

endmodule

### design/rrw_slots.sv
// ----------------------------------------------------------------------------
// rrw_slots: circular slot store of the reorder window
// Valid bits and a fill count in flops, descriptors in a memory. Slot i
// lives at physical entry (head + i) mod WINDOW_SLOTS; retiring the head
// advances the head pointer instead of shifting the window.
// ----------------------------------------------------------------------------
module rrw_slots #(
  parameter int unsigned WINDOW_SLOTS = 32,
  localparam int unsigned IW = $clog2(WINDOW_SLOTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrw_pkg::slot_cmd_t cmd_i,
  input  logic [IW-1:0]      wr_off_i,
  input  logic [31:0]        wr_data_i,
  output rrw_pkg::slot_stat_t stat_o,
  output logic [31:0]        rd_data_o
);

  localparam int unsigned CW = $clog2(WINDOW_SLOTS + 1);
  localparam logic [IW:0]   WRAP    = (IW + 1)'(WINDOW_SLOTS);
  localparam logic [IW-1:0] IDX_ONE = IW'(1);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [WINDOW_SLOTS-1:0] valid_q, valid_d;
  logic [IW-1:0]           base_q, base_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [31:0]             mem [WINDOW_SLOTS];
  logic [31:0]             rd_q;
  logic [IW-1:0]           wr_idx;
  logic [IW-1:0]           next_idx;

  // modular add of an offset below WINDOW_SLOTS to an index
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WRAP) begin
      s = s - WRAP;
    end
    return s[IW-1:0];
  endfunction

  assign wr_idx   = wrap_add(base_q, wr_off_i);
  assign next_idx = wrap_add(base_q, IDX_ONE);

  // valid bits, fill count and head pointer
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    if (cmd_i.clr) begin
      valid_d = '0;
      cnt_d   = '0;
    end else if (cmd_i.wr_en) begin
      valid_d[wr_idx] = 1'b1;
      if (!valid_q[wr_idx]) begin
        cnt_d = cnt_q + CNT_ONE;
      end
    end else if (cmd_i.pop) begin
      valid_d[base_q] = 1'b0;
      cnt_d           = cnt_q - CNT_ONE;
      base_d          = next_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      base_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
    end
  end

  // descriptor memory: one write port, registered read of the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.clr) begin
      mem[wr_idx] <= wr_data_i;
    end
    rd_q <= mem[base_q];
  end

  assign rd_data_o         = rd_q;
  assign stat_o.head_valid = valid_q[base_q];
  assign stat_o.next_valid = valid_q[next_idx];
  assign stat_o.empty      = (cnt_q == '0);

endmodule

### tb/sv/rrw_order_check.sv
// ----------------------------------------------------------------------------
// rrw_order_check: result checker for the receive reorder window
// Watches the configuration port and both channels, keeps its own copy of
// the window state, works out the deliveries and acks that each accepted
// request causes, and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module rrw_order_check #(
  parameter int unsigned SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  rrw_pkg::req_t req_i,
  input  logic          res_valid_i,
  input  logic          res_ready_i,
  input  rrw_pkg::res_t res_i,
  output int            fail_count_o,
  output int            pending_o
);

  // window state as seen from outside
  logic [31:0] next_seq;
  logic        held_vld  [SLOTS];
  logic [31:0] held_desc [SLOTS];
  logic        gap_mark;
  logic        ack_armed;

  rrw_pkg::res_t due_results[$];
  int            fails = 0;

  function automatic void clear_window();
    for (int i = 0; i < SLOTS; i++) begin
      held_vld[i]  = 1'b0;
      held_desc[i] = '0;
    end
    gap_mark  = 1'b0;
    ack_armed = 1'b0;
  endfunction

  // result carries the expected number as it stands after this result
  function automatic void queue_result(logic kind, logic [31:0] desc);
    rrw_pkg::res_t r;
    r.result_kind          = kind;
    r.delivered_descriptor = desc;
    r.ack_sequence         = next_seq;
    r.last                 = 1'b0;
    due_results.insert(due_results.size(), r);
  endfunction

  // hand out the head slot plus every consecutive held slot, then shift down
  function automatic void deliver_run();
    int run_len;
    run_len = 1;
    while (run_len < SLOTS && held_vld[run_len]) run_len++;
    for (int i = 0; i < run_len; i++) begin
      next_seq = next_seq + 32'd1;
      queue_result(rrw_pkg::KIND_DELIVER, held_desc[i]);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (i + run_len < SLOTS) begin
        held_vld[i]  = held_vld[i + run_len];
        held_desc[i] = held_desc[i + run_len];
      end else begin
        held_vld[i]  = 1'b0;
        held_desc[i] = '0;
      end
    end
  endfunction

  function automatic logic window_occupied();
    foreach (held_vld[i]) if (held_vld[i]) return 1'b1;
    return 1'b0;
  endfunction

  // apply one accepted request to the window and queue what it causes
  function automatic void advance_window(rrw_pkg::req_t rq);
    int            first;
    logic          handled;
    logic [31:0]   offset;
    rrw_pkg::res_t tail;
    first   = due_results.size();
    handled = 1'b0;
    if (rq.action == rrw_pkg::ACTION_TIMEOUT) begin
      if (held_vld[0]) begin
        deliver_run();
        queue_result(rrw_pkg::KIND_ACK, '0);
      end
      ack_armed = 1'b0;
    end else begin
      // a held in-order packet is flushed by whatever comes next
      if (ack_armed) begin
        ack_armed = 1'b0;
        if (rq.packet_sequence == next_seq + 32'd1) begin
          held_vld[1]  = 1'b1;
          held_desc[1] = rq.payload_descriptor;
          deliver_run();
          queue_result(rrw_pkg::KIND_ACK, '0);
          handled = 1'b1;
        end else if (rq.packet_sequence == next_seq) begin
          deliver_run();
          queue_result(rrw_pkg::KIND_ACK, '0);
          handled = 1'b1;
        end else begin
          deliver_run();
        end
      end
      if (!handled) begin
        offset = rq.packet_sequence - next_seq;
        if (offset == 32'd0) begin
          held_vld[0]  = 1'b1;
          held_desc[0] = rq.payload_descriptor;
          if (!gap_mark) begin
            ack_armed = 1'b1;
          end else begin
            deliver_run();
            gap_mark = window_occupied();
            queue_result(rrw_pkg::KIND_ACK, '0);
          end
        end else if (offset < rrw_pkg::HALF_RANGE) begin
          // ahead: stored only inside the window, acked either way
          gap_mark = 1'b1;
          if (offset < SLOTS) begin
            held_vld[offset]  = 1'b1;
            held_desc[offset] = rq.payload_descriptor;
          end
          queue_result(rrw_pkg::KIND_ACK, '0);
        end
      end
    end
    if (due_results.size() > first) begin
      tail      = due_results[due_results.size() - 1];
      tail.last = 1'b1;
      due_results[due_results.size() - 1] = tail;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endfunction

  // track configuration, requests and results at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    rrw_pkg::res_t want;
    if (!rst_ni) begin
      next_seq = '0;
      clear_window();
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        next_seq = cfg_wdata_i;
        clear_window();
      end
      if (req_valid_i && req_ready_i) advance_window(req_i);
      if (res_valid_i && res_ready_i) begin
        if (due_results.size() == 0) begin
          $display({"%0t: unexpected result: expected none, ",
                    "actual kind %0d desc %h ack %h last %0d"},
                   $time, res_i.result_kind, res_i.delivered_descriptor,
                   res_i.ack_sequence, res_i.last);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.result_kind, res_i.result_kind);
          check_field("delivered_descriptor", want.delivered_descriptor,
                      res_i.delivered_descriptor);
          check_field("ack_sequence", want.ack_sequence, res_i.ack_sequence);
          check_field("last", want.last, res_i.last);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_results.size();
  end

endmodule

### tb/sv/tb_receive_reorder_window.sv
// ----------------------------------------------------------------------------
// tb_receive_reorder_window: testbench top for the receive reorder window
// Drives directed packet and timeout requests through the special cases,
// then shuffled packet blocks with stale, early, far and random noise across
// several start sequences, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_receive_reorder_window;

  localparam int unsigned SLOTS = 32;
  // a request is followed by at most 33 results; even under random stalls
  // a long run with no handshake means a hang
  localparam int WATCHDOG_LIMIT = 1000;
  // covers the busy time of a request that causes no result
  localparam int SETTLE_CYCLES = 12;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        calm;
  logic        any_accept;
  int          pending;
  int          fail_count;
  int          stall_cycles = 0;

  rrw_stream_if #(.payload_t(rrw_pkg::req_t)) req_if ();
  rrw_stream_if #(.payload_t(rrw_pkg::res_t)) res_if ();

  receive_reorder_window #(.WINDOW_SLOTS(SLOTS)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  rrw_order_check #(.SLOTS(SLOTS)) order_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_i       (req_if.payload),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_i       (res_if.payload),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stalls at random unless in a calm stretch
  always @(posedge clk) begin
    res_if.ready <= rst_n && (calm || $urandom_range(99) >= 38);
  end

  assign any_accept = (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready);

  // hang detection
  always @(posedge clk) begin
    if (any_accept || cfg_we || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(logic act, logic [31:0] seq, logic [31:0] desc);
    rrw_pkg::req_t rq;
    rq.action             = act;
    rq.packet_sequence    = seq;
    rq.payload_descriptor = desc;
    while (!calm && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_data(logic [31:0] seq, logic [31:0] desc);
    send_request(rrw_pkg::ACTION_DATA, seq, desc);
  endtask

  task automatic send_timeout();
    send_request(rrw_pkg::ACTION_TIMEOUT, $urandom, $urandom);
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // shuffled blocks of consecutive packets, retransmitted now and then,
  // mixed with stale, early, far-ahead, random and timeout requests
  task automatic run_traffic(logic [31:0] start, int n_items);
    logic [31:0] base;
    int          order[$];
    int          span;
    int          sent;
    int          j;
    int          tmp;
    base = start;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) span = SLOTS - 1 + $urandom_range(2);
      else span = $urandom_range(8, 1);
      order.delete();
      for (int k = 0; k < span; k++) order.insert(order.size(), k);
      for (int k = span - 1; k > 0; k--) begin
        j        = $urandom_range(k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      foreach (order[k]) begin
        if ($urandom_range(99) < 25) begin
          case ($urandom_range(5))
            0, 1:    send_timeout();
            2:       send_data(base - $urandom_range(40, 1), $urandom);
            3:       send_data(base + $urandom_range(span - 1), $urandom);
            4:       send_data(base + span + SLOTS + $urandom_range(1000), $urandom);
            default: send_data($urandom, $urandom);
          endcase
          sent++;
        end
        send_data(base + order[k], $urandom);
        sent++;
      end
      // packets beyond the window are lost and must come again
      if (span > SLOTS || $urandom_range(3) == 0) begin
        for (int k = 0; k < span; k++) begin
          send_data(base + k, $urandom);
          sent++;
        end
      end
      base = base + span;
    end
  endtask

  initial begin
    logic [31:0] rand_start;
    rst_n          = 1'b0;
    calm           = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start sequence 0 from reset
    send_timeout();                            // empty window, no result
    send_data(32'd0, 32'hFFFF_FFFF);           // in order, ack held
    send_data(32'd1, 32'h0000_0000);           // next follows: deliver two, ack
    send_data(32'd2, 32'hA5A5_5A5A);           // ack held
    send_data(32'd2, 32'h1234_5678);           // duplicate of held packet
    send_data(32'd3, 32'h0F0F_F0F0);           // ack held
    send_data(32'd10, 32'hDEAD_0010);          // flush without ack, then ahead
    send_data(32'd44, 32'hDEAD_0044);          // ahead beyond the window
    send_data(32'h8000_0003, 32'hDEAD_BEEF);   // farthest ahead
    send_data(32'h8000_0004, 32'hBAD0_0001);   // half range away: old
    send_data(32'd0, 32'hBAD0_0002);           // old
    send_data(32'd4, 32'h0000_0004);           // fills part of the gap
    send_data(32'd5, 32'h0000_0005);
    send_data(32'd6, 32'h0000_0006);
    send_data(32'd7, 32'h0000_0007);
    send_data(32'd8, 32'h0000_0008);
    send_data(32'd9, 32'h0000_0009);           // closes the gap, run reaches 10
    send_data(32'd11, 32'h0000_0011);          // ack held
    send_timeout();                            // timeout flushes held packet
    send_data(32'd12, 32'h0000_0012);          // ack held
    send_data(32'd11, 32'hBAD0_0003);          // flush without ack, then old
    send_data(32'd13, 32'h0000_0013);          // ack held
    send_data(32'd20, 32'h0000_0020);          // flush, then ahead
    send_timeout();                            // head empty, no result
    send_data(32'd14, 32'h0000_0014);          // gap stays open

    // random traffic across start sequences
    write_start(32'hFFFF_FFF0);
    run_traffic(32'hFFFF_FFF0, 14);
    drain();
    calm <= 1'b1;
    write_start(32'h7FFF_FFF8);
    run_traffic(32'h7FFF_FFF8, 14);
    drain();
    calm <= 1'b0;
    rand_start = $urandom;
    write_start(rand_start);
    run_traffic(rand_start, 14);
    write_start(32'hFFFF_FFFF);
    run_traffic(32'hFFFF_FFFF, 14);
    write_start(32'h0000_0000);
    run_traffic(32'h0000_0000, 14);

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/rrw_pkg.sv
design/rrw_stream_if.sv
design/rrw_slots.sv
design/receive_reorder_window.sv
tb/sv/rrw_order_check.sv
tb/sv/tb_receive_reorder_window.sv
